[rtl/nnd_pkg.sv]
// Shared types and field widths for the nearest-neighbor downscaler.
package nnd_pkg;

  localparam int CH_W  = 8;
  localparam int IDX_W = 16;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic             hit;
    logic             last;
    logic [IDX_W-1:0] index;
  } pick_t;

endpackage

[rtl/nnd_in_stage.sv]
// Input register for incoming source pixel transactions.
module nnd_in_stage
  import nnd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  logic   drain,
  input  logic   frame_start_in,
  input  pixel_t pixel_in,
  output logic   valid,
  output logic   frame_start,
  output pixel_t pixel
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (drain) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_start <= frame_start_in;
      pixel       <= pixel_in;
    end
  end

endmodule

[rtl/nnd_pick.sv]
// Source and destination counters that decide which source pixels are kept.
module nnd_pick
  import nnd_pkg::*;
#(
  parameter int SRC_W = 240,
  parameter int SRC_H = 240,
  parameter int DST_W = 192,
  parameter int DST_H = 192
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  logic  frame_start,
  input  logic  pad_enable,
  output pick_t pick
);

  localparam int SCW = $clog2(SRC_W + 1);
  localparam int SRW = $clog2(SRC_H + 1);
  localparam int DCW = $clog2(DST_W + 1);
  localparam int DRW = $clog2(DST_H + 1);
  localparam int TCW = $clog2(2 * SRC_W + 2);
  localparam int TRW = $clog2(2 * SRC_H + 2);
  localparam int RCW = $clog2(2 * DST_W + 1);
  localparam int RRW = $clog2(2 * DST_H + 1);

  localparam int MAX_S  = (SRC_W > SRC_H) ? SRC_W : SRC_H;
  localparam int FW_RAW = (SRC_W * DST_W) / MAX_S;
  localparam int FH_RAW = (SRC_H * DST_W) / MAX_S;
  localparam int FDW_P  = (FW_RAW == 0) ? 1 : ((FW_RAW > DST_W) ? DST_W : FW_RAW);
  localparam int FDH_P  = (FH_RAW == 0) ? 1 : ((FH_RAW > DST_H) ? DST_H : FH_RAW);
  localparam int PADC_P = (DST_W - FDW_P) / 2;
  localparam int PADR_P = (DST_H - FDH_P) / 2;
  localparam int QW_P   = SRC_W / FDW_P;
  localparam int RW_P   = SRC_W % FDW_P;
  localparam int QH_P   = SRC_H / FDH_P;
  localparam int RH_P   = SRC_H % FDH_P;
  localparam int QW_U   = SRC_W / DST_W;
  localparam int RW_U   = SRC_W % DST_W;
  localparam int QH_U   = SRC_H / DST_H;
  localparam int RH_U   = SRC_H % DST_H;

  logic [SCW-1:0] src_col, src_col_next;
  logic [SRW-1:0] src_row, src_row_next;
  logic [DCW-1:0] dst_col, dst_col_next;
  logic [DRW-1:0] dst_row, dst_row_next;
  logic [TCW-1:0] target_col, target_col_next;
  logic [TRW-1:0] target_row, target_row_next;
  logic [RCW-1:0] col_remainder, col_remainder_next;
  logic [RRW-1:0] row_remainder, row_remainder_next;

  logic [SCW-1:0] sc;
  logic [SRW-1:0] sr;
  logic [DCW-1:0] dc;
  logic [DRW-1:0] dr;
  logic [TCW-1:0] tc, tc_adv;
  logic [TRW-1:0] tr, tr_adv;
  logic [RCW-1:0] rc, rc_adv;
  logic [RRW-1:0] rr, rr_adv;
  logic [RCW:0]   rc_sum;
  logic [RRW:0]   rr_sum;

  logic [DCW-1:0] fdw, pad_col;
  logic [DRW-1:0] fdh, pad_row;
  logic [TCW-1:0] q_col;
  logic [TRW-1:0] q_row;
  logic [RCW-1:0] r_col;
  logic [RRW-1:0] r_row;

  logic             row_hit, col_hit, row_end;
  logic [IDX_W-1:0] row_idx, index;

  always_comb begin
    fdw     = pad_enable ? DCW'(FDW_P)  : DCW'(DST_W);
    fdh     = pad_enable ? DRW'(FDH_P)  : DRW'(DST_H);
    pad_col = pad_enable ? DCW'(PADC_P) : '0;
    pad_row = pad_enable ? DRW'(PADR_P) : '0;
    q_col   = pad_enable ? TCW'(QW_P)   : TCW'(QW_U);
    r_col   = pad_enable ? RCW'(RW_P)   : RCW'(RW_U);
    q_row   = pad_enable ? TRW'(QH_P)   : TRW'(QH_U);
    r_row   = pad_enable ? RRW'(RH_P)   : RRW'(RH_U);
  end

  always_comb begin
    sc = frame_start ? '0 : src_col;
    sr = frame_start ? '0 : src_row;
    dc = frame_start ? '0 : dst_col;
    dr = frame_start ? '0 : dst_row;
    tc = frame_start ? '0 : target_col;
    tr = frame_start ? '0 : target_row;
    rc = frame_start ? '0 : col_remainder;
    rr = frame_start ? '0 : row_remainder;

    row_hit = (dr < fdh) && (TRW'(tr) <= TRW'(sr));
    col_hit = row_hit && (dc < fdw) && (tc <= TCW'(sc));
    row_end = (sc == SCW'(SRC_W - 1));

    rc_sum = {1'b0, rc} + {1'b0, r_col};
    if (rc_sum >= (RCW + 1)'(fdw)) begin
      rc_adv = RCW'(rc_sum - (RCW + 1)'(fdw));
      tc_adv = tc + q_col + TCW'(1);
    end else begin
      rc_adv = RCW'(rc_sum);
      tc_adv = tc + q_col;
    end

    rr_sum = {1'b0, rr} + {1'b0, r_row};
    if (rr_sum >= (RRW + 1)'(fdh)) begin
      rr_adv = RRW'(rr_sum - (RRW + 1)'(fdh));
      tr_adv = tr + q_row + TRW'(1);
    end else begin
      rr_adv = RRW'(rr_sum);
      tr_adv = tr + q_row;
    end

    row_idx = IDX_W'(dr) + IDX_W'(pad_row);
    index   = IDX_W'(row_idx * IDX_W'(DST_W)) + IDX_W'(dc) + IDX_W'(pad_col);

    pick.hit   = col_hit;
    pick.last  = (dc == fdw - DCW'(1)) && (dr == fdh - DRW'(1));
    pick.index = index;

    if (row_end) begin
      src_col_next       = '0;
      src_row_next       = (sr < SRW'(SRC_H)) ? sr + SRW'(1) : sr;
      dst_col_next       = '0;
      target_col_next    = '0;
      col_remainder_next = '0;
      dst_row_next       = row_hit ? dr + DRW'(1) : dr;
      target_row_next    = row_hit ? tr_adv : tr;
      row_remainder_next = row_hit ? rr_adv : rr;
    end else begin
      src_col_next       = sc + SCW'(1);
      src_row_next       = sr;
      dst_col_next       = col_hit ? dc + DCW'(1) : dc;
      target_col_next    = col_hit ? tc_adv : tc;
      col_remainder_next = col_hit ? rc_adv : rc;
      dst_row_next       = dr;
      target_row_next    = tr;
      row_remainder_next = rr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col       <= '0;
      src_row       <= '0;
      dst_col       <= '0;
      dst_row       <= '0;
      target_col    <= '0;
      target_row    <= '0;
      col_remainder <= '0;
      row_remainder <= '0;
    end else if (step) begin
      src_col       <= src_col_next;
      src_row       <= src_row_next;
      dst_col       <= dst_col_next;
      dst_row       <= dst_row_next;
      target_col    <= target_col_next;
      target_row    <= target_row_next;
      col_remainder <= col_remainder_next;
      row_remainder <= row_remainder_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_dst_col_bound: assert property (@(posedge clk) disable iff (rst)
    dst_col <= DCW'(DST_W))
    else $error("dst_col beyond destination width");

  a_src_row_bound: assert property (@(posedge clk) disable iff (rst)
    src_row <= SRW'(SRC_H))
    else $error("src_row beyond source height");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    step && frame_start |=> dst_row == '0 || dst_row == DRW'(1))
    else $error("frame start did not restart destination rows");

  a_hit_in_frame: assert property (@(posedge clk) disable iff (rst)
    pick.hit |-> dst_row < DRW'(DST_H) && dst_col < DCW'(DST_W) || frame_start)
    else $error("pick outside destination frame");
`endif

endmodule

[rtl/nnd_out_stage.sv]
// Output register for destination pixel transactions.
module nnd_out_stage
  import nnd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             ready,
  input  pick_t            pick,
  input  pixel_t           pixel_in,
  output logic             valid,
  output logic             last,
  output logic [IDX_W-1:0] index,
  output pixel_t           pixel
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= pick.hit;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && pick.hit) begin
      last  <= pick.last;
      index <= pick.index;
      pixel <= pixel_in;
    end
  end

endmodule

[rtl/nearest_neighbor_downscale_core.sv]
// Nearest-neighbor downscaler top level: stream ports, config register, stages.
// A pixel goes through the input register, then the output register, to m_tdata.
// Throughput: one pixel per cycle unless m_tready stalls; zero or one result each.
// The input register feeds the pick logic straight into the output register.
// Reset (rst, synchronous): clears all counters, valid flags and pad_enable.
// No frame_start after reset: the first pixel starts a frame.
module nearest_neighbor_downscale_core
  import nnd_pkg::*;
#(
  parameter int SRC_W = 240,
  parameter int SRC_H = 240,
  parameter int DST_W = 192,
  parameter int DST_H = 192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // pad_enable
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,       // in_red, in_green, in_blue
  input  logic        s_tuser,       // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,       // dst_pixel_index, out_red, out_green, out_blue
  output logic        m_tlast        // frame_last
);

  logic             pad_enable;
  logic             in_valid, in_frame_start, advance, load_in;
  pixel_t           in_pixel, out_pixel;
  pick_t            pick;
  logic [IDX_W-1:0] out_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      pad_enable <= cfg_wr_data;
    end
  end

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign load_in  = s_tvalid && s_tready;

  nnd_in_stage u_in (
    .clk            (clk),
    .rst            (rst),
    .load           (load_in),
    .drain          (advance),
    .frame_start_in (s_tuser),
    .pixel_in       (s_tdata),
    .valid          (in_valid),
    .frame_start    (in_frame_start),
    .pixel          (in_pixel)
  );

  nnd_pick #(
    .SRC_W (SRC_W),
    .SRC_H (SRC_H),
    .DST_W (DST_W),
    .DST_H (DST_H)
  ) u_pick (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .frame_start (in_frame_start),
    .pad_enable  (pad_enable),
    .pick        (pick)
  );

  nnd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .ready    (m_tready),
    .pick     (pick),
    .pixel_in (in_pixel),
    .valid    (m_tvalid),
    .last     (m_tlast),
    .index    (out_index),
    .pixel    (out_pixel)
  );

  assign m_tdata = {out_pixel, out_index};

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !advance)
    else $error("pending result overwritten");

  a_step_needs_item: assert property (@(posedge clk) disable iff (rst)
    advance |-> in_valid)
    else $error("counters stepped without a pixel");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load_in && in_valid |-> advance)
    else $error("input register overwritten");
`endif

endmodule

[verif/nearest_neighbor_downscale_core_tb.sv]
// Self-checking testbench for the downscaler: random stream traffic, predicted writes.
`timescale 1ns / 100ps

module nearest_neighbor_downscale_core_tb;
  import nnd_pkg::*;

  localparam int SRC_W = 240;
  localparam int SRC_H = 240;
  localparam int DST_W = 192;
  localparam int DST_H = 192;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned SINK_HOLD_CYCLES = 400;
  localparam int unsigned MAX_REPORTS = 200;

  typedef struct {
    logic [IDX_W-1:0] index;
    pixel_t           px;
    logic             last;
  } dst_write_t;

  class DownscaleScoreboard;
    bit          pad_on;
    int unsigned src_col, src_row, dst_col, dst_row;
    int unsigned tgt_col, tgt_row, col_rem, row_rem;
    dst_write_t  writes_due[$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      pad_on = 1'b0;
      errors = 0;
      results_seen = 0;
      clear_frame();
    endfunction

    function void clear_cols();
      dst_col = 0;
      tgt_col = 0;
      col_rem = 0;
    endfunction

    function void clear_frame();
      src_col = 0;
      src_row = 0;
      dst_row = 0;
      tgt_row = 0;
      row_rem = 0;
      clear_cols();
    endfunction

    function void set_pad(bit value);
      pad_on = value;
    endfunction

    function int unsigned pending();
      return writes_due.size();
    endfunction

    function int unsigned fit_len(int unsigned side, int unsigned lim);
      int unsigned longest, f;
      longest = (SRC_W > SRC_H) ? SRC_W : SRC_H;
      f = (side * DST_W) / longest;
      if (f == 0) f = 1;
      if (f > lim) f = lim;
      return f;
    endfunction

    function void step_ratio(ref int unsigned target, ref int unsigned rem,
                             input int unsigned span, input int unsigned fd);
      target += span / fd;
      rem += span % fd;
      if (rem >= fd) begin
        rem -= fd;
        target += 1;
      end
    endfunction

    function void note_pixel(bit frame_start, pixel_t px);
      int unsigned fit_w, fit_h, off_col, off_row, idx;
      bit row_due;
      dst_write_t w;
      if (pad_on) begin
        fit_w = fit_len(SRC_W, DST_W);
        fit_h = fit_len(SRC_H, DST_H);
        off_col = (DST_W - fit_w) / 2;
        off_row = (DST_H - fit_h) / 2;
      end else begin
        fit_w = DST_W;
        fit_h = DST_H;
        off_col = 0;
        off_row = 0;
      end
      if (frame_start) clear_frame();
      row_due = (dst_row < fit_h) && (tgt_row <= src_row);
      if (row_due && dst_col < fit_w && tgt_col <= src_col) begin
        idx = (dst_row + off_row) * DST_W + dst_col + off_col;
        w.index = idx[IDX_W-1:0];
        w.px = px;
        w.last = (dst_col == fit_w - 1) && (dst_row == fit_h - 1);
        writes_due.push_back(w);
        dst_col += 1;
        step_ratio(tgt_col, col_rem, SRC_W, fit_w);
      end
      if (src_col + 1 >= SRC_W) begin
        if (row_due) begin
          dst_row += 1;
          step_ratio(tgt_row, row_rem, SRC_H, fit_h);
        end
        clear_cols();
        src_col = 0;
        if (src_row < SRC_H) src_row += 1;
      end else begin
        src_col += 1;
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH: %s", what);
    endtask

    task compare_field(string name, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("write %0d %s: got %0h, expected %0h",
                                  results_seen, name, got, want));
    endtask

    task check_result(logic [39:0] data, logic last);
      dst_write_t w;
      results_seen++;
      if (writes_due.size() == 0) begin
        report_mismatch($sformatf("write %0d to index %0d with none pending",
                                  results_seen, data[15:0]));
        return;
      end
      w = writes_due.pop_front();
      compare_field("index", data[15:0], w.index);
      compare_field("red", IDX_W'(data[23:16]), IDX_W'(w.px.red));
      compare_field("green", IDX_W'(data[31:24]), IDX_W'(w.px.green));
      compare_field("blue", IDX_W'(data[39:32]), IDX_W'(w.px.blue));
      compare_field("frame_last", IDX_W'(last), IDX_W'(w.last));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // in_red, in_green, in_blue
  logic        s_tuser;    // frame_start
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;    // dst_pixel_index, out_red, out_green, out_blue
  logic        m_tlast;    // frame_last

  DownscaleScoreboard sb;
  bit calm;

  nearest_neighbor_downscale_core #(
    .SRC_W(SRC_W),
    .SRC_H(SRC_H),
    .DST_W(DST_W),
    .DST_H(DST_H)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_pixel(input bit fs, input pixel_t px);
    bit taken;
    while (!calm && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    s_tuser <= fs;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (s_tready) begin
        taken = 1'b1;
        sb.note_pixel(fs, px);
      end
      @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pad(input bit value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_pad(value);
  endtask

  task automatic send_frame(input int unsigned length, input bit noisy);
    bit fs;
    for (int unsigned i = 0; i < length; i++) begin
      fs = (i == 0) || (noisy && $urandom_range(199) == 0);
      send_pixel(fs, 24'($urandom));
    end
  endtask

  // sink: random backpressure plus one long hold-off while the sender is offering
  initial begin : sink
    int unsigned hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && sb != null && sb.results_seen >= 100 && s_tvalid) begin
        held_once = 1'b1;
        hold_left = SINK_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    calm = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first pixels with no frame start, then extreme channel patterns
    send_pixel(1'b0, 24'h000000);
    send_pixel(1'b0, 24'hFFFFFF);
    send_pixel(1'b0, 24'hAA55AA);
    send_pixel(1'b0, 24'h55AA55);
    send_pixel(1'b0, 24'h7F8001);
    send_pixel(1'b0, 24'h807FFE);
    send_pixel(1'b1, 24'hFFFFFF);
    send_pixel(1'b0, 24'h000000);
    send_pixel(1'b0, 24'h123456);

    // padding switched on mid-frame, counters kept
    write_pad(1'b1);
    send_pixel(1'b0, 24'hFF00FF);
    send_pixel(1'b0, 24'h00FF00);
    send_pixel(1'b1, 24'h0F0F0F);
    send_pixel(1'b0, 24'hF0F0F0);
    write_pad(1'b0);

    for (int k = 0; k < 6; k++) begin
      send_frame(($urandom_range(3) == 0) ? $urandom_range(1, 20) : $urandom_range(30, 70),
                 k[0]);
      if (k == 2) write_pad(1'b1);
      else if (k == 4) write_pad(1'b0);
      else if ($urandom_range(1)) drain();
    end

    // one full source row and part of the next, with no idling
    write_pad(1'b1);
    calm = 1'b1;
    send_frame(SRC_W + 40, 1'b0);
    calm = 1'b0;

    write_pad(1'b0);
    send_frame($urandom_range(10, 30), 1'b1);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[nearest_neighbor_downscale_core.f]
rtl/nnd_pkg.sv
rtl/nnd_in_stage.sv
rtl/nnd_pick.sv
rtl/nnd_out_stage.sv
rtl/nearest_neighbor_downscale_core.sv
verif/nearest_neighbor_downscale_core_tb.sv
